[hdl/nps_pkg.sv]
`timescale 1ns / 1ps

package nps_pkg;

   localparam int MAX_JOBS  = 16;
   localparam int IDX_W     = $clog2(MAX_JOBS);
   localparam int CNT_W     = $clog2(MAX_JOBS + 1);
   localparam int ARR_W     = 16;
   localparam int BURST_W   = 16;
   localparam int PRIO_W    = 8;
   localparam int TIME_W    = 21;
   localparam int JOB_NUM_W = 5;
   localparam int STEP_W    = 3;

   localparam logic [TIME_W-1:0] TIME_MAX = '1;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_RUN  = 1'b1;

   typedef struct packed {
      logic               cmd;
      logic [ARR_W-1:0]   arrival;
      logic [BURST_W-1:0] burst;
      logic [PRIO_W-1:0]  priority_req;
   } req_type;

   typedef struct packed {
      logic [JOB_NUM_W-1:0] job_number;
      logic [TIME_W-1:0]    completion;
      logic [TIME_W-1:0]    turnaround;
      logic [TIME_W-1:0]    waiting;
      logic                 overflow;
      logic                 last;
   } rsp_type;

   typedef enum logic [2:0] {
      OP_WAIT,
      OP_INIT,
      OP_SCAN_ARR,
      OP_SETTLE,
      OP_SCAN_PICK,
      OP_EXEC,
      OP_EMIT,
      OP_FINISH
   } op_type;

   typedef enum logic [2:0] {
      CND_REQ,
      CND_NEXT,
      CND_LOOP,
      CND_EMIT,
      CND_JUMP
   } cond_type;

   typedef struct packed {
      op_type             op;
      cond_type           cond;
      logic [STEP_W-1:0]  target;
   } ucode_type;

   localparam logic [STEP_W-1:0] STEP_WAIT      = 3'd0;
   localparam logic [STEP_W-1:0] STEP_INIT      = 3'd1;
   localparam logic [STEP_W-1:0] STEP_SCAN_ARR  = 3'd2;
   localparam logic [STEP_W-1:0] STEP_SETTLE    = 3'd3;
   localparam logic [STEP_W-1:0] STEP_SCAN_PICK = 3'd4;
   localparam logic [STEP_W-1:0] STEP_EXEC      = 3'd5;
   localparam logic [STEP_W-1:0] STEP_EMIT      = 3'd6;
   localparam logic [STEP_W-1:0] STEP_FINISH    = 3'd7;

   function automatic ucode_type ucode_word(input logic [STEP_W-1:0] step);
      ucode_type w;
      case (step)
         STEP_WAIT:      w = '{op: OP_WAIT,      cond: CND_REQ,  target: STEP_INIT};
         STEP_INIT:      w = '{op: OP_INIT,      cond: CND_NEXT, target: STEP_WAIT};
         STEP_SCAN_ARR:  w = '{op: OP_SCAN_ARR,  cond: CND_LOOP, target: STEP_WAIT};
         STEP_SETTLE:    w = '{op: OP_SETTLE,    cond: CND_NEXT, target: STEP_WAIT};
         STEP_SCAN_PICK: w = '{op: OP_SCAN_PICK, cond: CND_LOOP, target: STEP_WAIT};
         STEP_EXEC:      w = '{op: OP_EXEC,      cond: CND_NEXT, target: STEP_WAIT};
         STEP_EMIT:      w = '{op: OP_EMIT,      cond: CND_EMIT, target: STEP_SCAN_ARR};
         STEP_FINISH:    w = '{op: OP_FINISH,    cond: CND_JUMP, target: STEP_WAIT};
         default:        w = '{op: OP_FINISH,    cond: CND_JUMP, target: STEP_WAIT};
      endcase
      return w;
   endfunction

endpackage

[hdl/nonpreemptive_priority_scheduler_top.sv]
`timescale 1ns / 1ps

// Non-preemptive priority scheduler. A load item (cmd 0) stores one job and is
// answered in the next cycle by a single reply with last set, and overflow set
// when the table was full. A run item (cmd 1) schedules the n stored jobs and
// returns n results in execution order, the final one with last set; with an
// empty table a run returns nothing. A small microcode program steps through
// the job table, one entry per cycle over a single read port: each selection
// scans for the earliest arrival, settles the clock, scans again to pick the
// job, executes it and emits it, waiting at the emit step while the output is
// stalled. The table is emptied after each run; no item is taken while a run
// is busy.
module nonpreemptive_priority_scheduler_top
   import nps_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic [ARR_W-1:0]   arrival_ff [MAX_JOBS];
   logic [BURST_W-1:0] burst_ff   [MAX_JOBS];
   logic [PRIO_W-1:0]  prio_ff    [MAX_JOBS];

   logic [STEP_W-1:0]   step_ff, step_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [MAX_JOBS-1:0] done_ff, done_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;

   logic [TIME_W-1:0]  now_ff, now_in;
   logic [IDX_W-1:0]   scan_ff, scan_in;
   logic [IDX_W-1:0]   emit_ff, emit_in;
   logic               any_ff, any_in;
   logic [ARR_W-1:0]   earliest_ff, earliest_in;
   logic               best_valid_ff, best_valid_in;
   logic [IDX_W-1:0]   best_ff, best_in;
   logic [ARR_W-1:0]   best_arr_ff, best_arr_in;
   logic [BURST_W-1:0] best_burst_ff, best_burst_in;
   logic [PRIO_W-1:0]  best_prio_ff, best_prio_in;
   logic [TIME_W-1:0]  tat_ff, tat_in;

   ucode_type          uword;
   logic               out_free;
   logic               req_fire;
   logic               full;
   logic               load_we;
   logic               scan_last;
   logic               more;
   logic [ARR_W-1:0]   cur_arr;
   logic [BURST_W-1:0] cur_burst;
   logic [PRIO_W-1:0]  cur_prio;
   logic               cur_arrived;
   logic               cur_prefer;
   logic [TIME_W:0]    sum;
   logic [TIME_W-1:0]  comp;
   logic [TIME_W-1:0]  burst_ext;

   assign uword     = ucode_word(step_ff);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (uword.op == OP_WAIT) && out_free;
   assign req_fire  = req_valid && req_ready;
   assign full      = (count_ff == CNT_W'(MAX_JOBS));
   assign load_we   = req_fire && (req_data.cmd == CMD_LOAD) && !full;
   assign scan_last = ((CNT_W'(scan_ff) + 1'b1) == count_ff);
   assign more      = ((CNT_W'(emit_ff) + 1'b1) != count_ff);

   assign cur_arr     = arrival_ff[scan_ff];
   assign cur_burst   = burst_ff[scan_ff];
   assign cur_prio    = prio_ff[scan_ff];
   assign cur_arrived = (TIME_W'(cur_arr) <= now_ff);
   assign cur_prefer  = !best_valid_ff || (cur_prio < best_prio_ff)
                        || ((cur_prio == best_prio_ff) && (cur_arr < best_arr_ff));

   assign sum       = {1'b0, now_ff} + (TIME_W + 1)'(best_burst_ff);
   assign comp      = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
   assign burst_ext = TIME_W'(best_burst_ff);

   always_comb begin
      step_in       = step_ff;
      count_in      = count_ff;
      done_in       = done_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_in        = rsp_ff;
      now_in        = now_ff;
      scan_in       = scan_ff;
      emit_in       = emit_ff;
      any_in        = any_ff;
      earliest_in   = earliest_ff;
      best_valid_in = best_valid_ff;
      best_in       = best_ff;
      best_arr_in   = best_arr_ff;
      best_burst_in = best_burst_ff;
      best_prio_in  = best_prio_ff;
      tat_in        = tat_ff;

      case (uword.op)
         OP_WAIT: begin
            if (req_fire && req_data.cmd == CMD_LOAD) begin
               if (!full) begin
                  count_in = count_ff + 1'b1;
               end
               rsp_in       = '{job_number: '0, completion: '0, turnaround: '0,
                                waiting: '0, overflow: full, last: 1'b1};
               rsp_valid_in = 1'b1;
            end
         end
         OP_INIT: begin
            now_in      = '0;
            emit_in     = '0;
            scan_in     = '0;
            any_in      = 1'b0;
            earliest_in = '1;
         end
         OP_SCAN_ARR: begin
            if (!done_ff[scan_ff]) begin
               if (cur_arrived) begin
                  any_in = 1'b1;
               end else if (cur_arr < earliest_ff) begin
                  earliest_in = cur_arr;
               end
            end
            scan_in = scan_last ? '0 : scan_ff + 1'b1;
         end
         OP_SETTLE: begin
            if (!any_ff) begin
               now_in = TIME_W'(earliest_ff);
            end
            best_valid_in = 1'b0;
         end
         OP_SCAN_PICK: begin
            if (!done_ff[scan_ff] && cur_arrived && cur_prefer) begin
               best_valid_in = 1'b1;
               best_in       = scan_ff;
               best_arr_in   = cur_arr;
               best_burst_in = cur_burst;
               best_prio_in  = cur_prio;
            end
            scan_in = scan_last ? '0 : scan_ff + 1'b1;
         end
         OP_EXEC: begin
            now_in           = comp;
            done_in[best_ff] = 1'b1;
            tat_in           = comp - TIME_W'(best_arr_ff);
         end
         OP_EMIT: begin
            if (out_free) begin
               rsp_in.job_number = JOB_NUM_W'({1'b0, best_ff} + 1'b1);
               rsp_in.completion = now_ff;
               rsp_in.turnaround = tat_ff;
               rsp_in.waiting    = (tat_ff >= burst_ext) ? tat_ff - burst_ext : '0;
               rsp_in.overflow   = 1'b0;
               rsp_in.last       = !more;
               rsp_valid_in      = 1'b1;
               emit_in           = emit_ff + 1'b1;
               any_in            = 1'b0;
               earliest_in       = '1;
            end
         end
         OP_FINISH: begin
            count_in = '0;
            done_in  = '0;
         end
         default: begin
         end
      endcase

      case (uword.cond)
         CND_REQ: begin
            if (req_fire && req_data.cmd == CMD_RUN && count_ff != '0) begin
               step_in = uword.target;
            end
         end
         CND_NEXT: step_in = step_ff + 1'b1;
         CND_LOOP: begin
            if (scan_last) begin
               step_in = step_ff + 1'b1;
            end
         end
         CND_EMIT: begin
            if (out_free) begin
               step_in = more ? uword.target : step_ff + 1'b1;
            end
         end
         CND_JUMP: step_in = uword.target;
         default:  step_in = STEP_WAIT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= STEP_WAIT;
         count_ff     <= '0;
         done_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         count_ff     <= count_in;
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff        <= rsp_in;
      now_ff        <= now_in;
      scan_ff       <= scan_in;
      emit_ff       <= emit_in;
      any_ff        <= any_in;
      earliest_ff   <= earliest_in;
      best_valid_ff <= best_valid_in;
      best_ff       <= best_in;
      best_arr_ff   <= best_arr_in;
      best_burst_ff <= best_burst_in;
      best_prio_ff  <= best_prio_in;
      tat_ff        <= tat_in;
   end

   always_ff @(posedge clock) begin
      if (load_we) begin
         arrival_ff[count_ff[IDX_W-1:0]] <= req_data.arrival;
         burst_ff[count_ff[IDX_W-1:0]]   <= req_data.burst;
         prio_ff[count_ff[IDX_W-1:0]]    <= req_data.priority_req;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef ASSERT_OFF
   a_done_clear_idle: assert property (@(posedge clock) disable iff (reset)
      step_ff == STEP_WAIT |-> done_ff == '0)
      else $error("done flags set while idle");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_JOBS))
      else $error("job count beyond table size");

   a_exec_has_pick: assert property (@(posedge clock) disable iff (reset)
      step_ff == STEP_EXEC |-> best_valid_ff)
      else $error("execute step without a selected job");

   a_last_result: assert property (@(posedge clock) disable iff (reset)
      step_ff == STEP_EMIT && out_free && !more |=> rsp_valid_ff && rsp_ff.last)
      else $error("final result of a run not flagged last");
`endif

endmodule

[test/tb.sv]
`timescale 1ns / 1ps

module tb
   import nps_pkg::*;
;

   class sched_scoreboard;
      logic [ARR_W-1:0]   arrival_tab[MAX_JOBS];
      logic [BURST_W-1:0] burst_tab[MAX_JOBS];
      logic [PRIO_W-1:0]  prio_tab[MAX_JOBS];
      int unsigned        stored_jobs;
      rsp_type            expected_q[$];
      int                 errors;

      function new();
         stored_jobs = 0;
         errors      = 0;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // Non-preemptive pick: lowest priority number, then earliest arrival,
      // then lowest job number; idle to the earliest arrival when none is ready.
      function void note_item(req_type item);
         rsp_type     res;
         bit          done[MAX_JOBS];
         int unsigned clk_now;
         int unsigned earliest;
         int unsigned comp;
         int unsigned tat;
         int          pick;
         bit          ready_any;
         if (item.cmd == CMD_LOAD) begin
            res = '0;
            res.last = 1'b1;
            if (stored_jobs < MAX_JOBS) begin
               arrival_tab[stored_jobs] = item.arrival;
               burst_tab[stored_jobs]   = item.burst;
               prio_tab[stored_jobs]    = item.priority_req;
               stored_jobs++;
            end else begin
               res.overflow = 1'b1;
            end
            expected_q.push_back(res);
            return;
         end
         if (stored_jobs == 0)
            return;
         clk_now = 0;
         foreach (done[i])
            done[i] = 1'b0;
         for (int k = 0; k < stored_jobs; k++) begin
            ready_any = 1'b0;
            earliest  = 32'hFFFF_FFFF;
            for (int i = 0; i < stored_jobs; i++) begin
               if (!done[i]) begin
                  if (arrival_tab[i] <= clk_now)
                     ready_any = 1'b1;
                  if (arrival_tab[i] < earliest)
                     earliest = arrival_tab[i];
               end
            end
            if (!ready_any)
               clk_now = earliest;
            pick = -1;
            for (int i = 0; i < stored_jobs; i++) begin
               if (!done[i] && arrival_tab[i] <= clk_now) begin
                  if (pick < 0)
                     pick = i;
                  else if (prio_tab[i] < prio_tab[pick])
                     pick = i;
                  else if (prio_tab[i] == prio_tab[pick] &&
                           arrival_tab[i] < arrival_tab[pick])
                     pick = i;
               end
            end
            comp = clk_now + burst_tab[pick];
            if (comp > TIME_MAX)
               comp = TIME_MAX;
            clk_now    = comp;
            done[pick] = 1'b1;
            tat = comp - arrival_tab[pick];
            res = '0;
            res.job_number = JOB_NUM_W'(pick + 1);
            res.completion = TIME_W'(comp);
            res.turnaround = TIME_W'(tat);
            res.waiting    = (tat >= burst_tab[pick]) ? TIME_W'(tat - burst_tab[pick]) : '0;
            res.last       = (k + 1 == stored_jobs);
            expected_q.push_back(res);
         end
         stored_jobs = 0;
      endfunction

      task report(string msg);
         $display("[%0t] mismatch: %s", $time, msg);
         errors++;
      endtask

      task compare_field(string name, logic [31:0] got_v, logic [31:0] exp_v);
         if (got_v !== exp_v)
            report($sformatf("%s got %0d expected %0d", name, got_v, exp_v));
      endtask

      task check_result(rsp_type got);
         rsp_type exp_r;
         if (expected_q.size() == 0) begin
            report($sformatf("unexpected result job %0d", got.job_number));
            return;
         end
         exp_r = expected_q.pop_front();
         compare_field("job_number", got.job_number, exp_r.job_number);
         compare_field("completion", got.completion, exp_r.completion);
         compare_field("turnaround", got.turnaround, exp_r.turnaround);
         compare_field("waiting", got.waiting, exp_r.waiting);
         compare_field("overflow", got.overflow, exp_r.overflow);
         compare_field("last", got.last, exp_r.last);
      endtask
   endclass

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   sched_scoreboard sb = new();

   int items_sent  = 0;
   int burst_left  = 0;
   int phase_left  = 0;
   int ready_mode  = 0;
   logic hold_off  = 1'b0;

   nonpreemptive_priority_scheduler_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   task automatic send_item(req_type item);
      int gap;
      req_valid <= 1'b1;
      req_data  <= item;
      do
         @(posedge clock);
      while (req_ready !== 1'b1);
      sb.note_item(item);
      items_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = $urandom_range(0, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(0, 40);
      end
   endtask

   task automatic send_load(int arr, int bst, int prio);
      send_item('{cmd: CMD_LOAD, arrival: ARR_W'(arr), burst: BURST_W'(bst),
                  priority_req: PRIO_W'(prio)});
   endtask

   task automatic send_run();
      send_item('{cmd: CMD_RUN, arrival: ARR_W'($urandom), burst: BURST_W'($urandom),
                  priority_req: PRIO_W'($urandom)});
   endtask

   task automatic load_batch(int count);
      int style;
      style = $urandom_range(0, 3);
      for (int i = 0; i < count; i++) begin
         case (style)
            0: send_load($urandom_range(0, 20), $urandom_range(0, 10), $urandom_range(0, 3));
            1: send_load($urandom, $urandom, $urandom);
            2: send_load($urandom_range(0, 65535), $urandom_range(0, 50),
                         $urandom_range(0, 255));
            default: send_load(i * $urandom_range(0, 4000), $urandom_range(0, 3000),
                               $urandom_range(0, 7));
         endcase
      end
   endtask

   // Receiver: phases of always-ready, coin-flip and mostly-stalled.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (phase_left == 0) begin
            phase_left = $urandom_range(10, 80);
            ready_mode = $urandom_range(0, 2);
         end else begin
            phase_left--;
         end
         if (hold_off)
            rsp_ready <= 1'b0;
         else if (ready_mode == 0)
            rsp_ready <= 1'b1;
         else if (ready_mode == 1)
            rsp_ready <= $urandom_range(0, 1);
         else
            rsp_ready <= ($urandom_range(0, 3) == 0);
      end
   end

   initial begin
      wait (items_sent >= 60);
      @(posedge clock);
      hold_off <= 1'b1;
      repeat (400) @(posedge clock);
      hold_off <= 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1)
         sb.check_result(rsp_data);
   end

   initial begin
      int pick_r;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: empty run, zero burst with idle, extremes, tie breaks
      send_run();
      send_load(100, 0, 5);
      send_load(65535, 65535, 255);
      send_load(0, 10, 255);
      send_load(0, 20, 255);
      send_load(5, 7, 0);
      send_load(5, 3, 0);
      send_run();
      // full table, one load past capacity
      for (int i = 0; i < MAX_JOBS; i++)
         send_load(0, 65535 - i, $urandom_range(0, 255));
      send_load(65535, 65535, 255);
      send_run();

      while (items_sent < 425) begin
         pick_r = $urandom_range(0, 99);
         if (pick_r < 85) begin
            if ($urandom_range(0, 9) == 0)
               load_batch($urandom_range(15, 18));
            else
               load_batch($urandom_range(1, 8));
            send_run();
         end else if (pick_r < 93) begin
            send_run();
         end else begin
            load_batch(1);
         end
      end
      send_run();

      req_valid <= 1'b0;
      while (sb.pending() != 0)
         @(posedge clock);
      repeat (50) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      #20_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

[nonpreemptive_priority_scheduler_top.f]
hdl/nps_pkg.sv
hdl/nonpreemptive_priority_scheduler_top.sv
test/tb.sv
